FILE: design/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame decoder.
`timescale 1ns / 1ps
package htfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RawW  = 20;
  localparam int unsigned HumW  = 14;
  localparam int unsigned TempW = 15;
  localparam int unsigned PosW  = 3;

  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [ByteW-1:0] CrcInit = 8'hFF;

  // byte_position codes
  localparam logic [PosW-1:0] PosFirstHum = 3'd1;
  localparam logic [PosW-1:0] PosSecHum   = 3'd2;
  localparam logic [PosW-1:0] PosSplit    = 3'd3;
  localparam logic [PosW-1:0] PosFirstTmp = 3'd4;
  localparam logic [PosW-1:0] PosSecTmp   = 3'd5;
  localparam logic [PosW-1:0] PosCrc      = 3'd6;
  localparam logic [PosW-1:0] PosIdle     = 3'd7;

  // scale factors: centi = floor(raw * scale / 2^20), less the offset for temperature
  localparam logic [HumW-1:0]  HumScale   = 14'd10000;
  localparam logic [TempW-1:0] TempScale  = 15'd20000;
  localparam logic [TempW-1:0] TempOffset = 15'd5000;

  typedef struct packed {
    logic             crc_ok;
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] status;
    logic [RawW-1:0]  raw_hum;
    logic [RawW-1:0]  raw_tmp;
  } frame_t;

  // MSB-first CRC-8, one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      else            c = {c[ByteW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/htfd_assembler.sv
// Frame assembly: byte position, running CRC, raw value shifters, frame register.
`timescale 1ns / 1ps
module htfd_assembler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                frame_valid_o,
  input  logic                frame_ready_i,
  output htfd_pkg::frame_t    frame_o
);
  import htfd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] status_q, status_d;
  logic [RawW-1:0]  hum_q, hum_d;
  logic [RawW-1:0]  temp_q, temp_d;
  logic             fvalid_q, fvalid_d;
  frame_t           frame_q, frame_d;
  logic             accept;
  logic             emit;
  logic             ok;

  assign in_ready_o = !fvalid_q || frame_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ok         = (rx_byte_i == crc_q);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    status_d = status_q;
    hum_d    = hum_q;
    temp_d   = temp_q;
    emit     = 1'b0;
    if (accept) begin
      if (frame_start_i) begin
        status_d = rx_byte_i;
        crc_d    = crc8_byte(CrcInit, rx_byte_i);
        hum_d    = '0;
        temp_d   = '0;
        pos_d    = PosFirstHum;
      end else begin
        unique case (pos_q)
          PosFirstHum, PosSecHum: begin
            hum_d = {hum_q[RawW-ByteW-1:0], rx_byte_i};
            crc_d = crc8_byte(crc_q, rx_byte_i);
            pos_d = pos_q + 3'd1;
          end
          PosSplit: begin
            hum_d  = {hum_q[RawW-5:0], rx_byte_i[7:4]};
            temp_d = {16'd0, rx_byte_i[3:0]};
            crc_d  = crc8_byte(crc_q, rx_byte_i);
            pos_d  = pos_q + 3'd1;
          end
          PosFirstTmp, PosSecTmp: begin
            temp_d = {temp_q[RawW-ByteW-1:0], rx_byte_i};
            crc_d  = crc8_byte(crc_q, rx_byte_i);
            pos_d  = pos_q + 3'd1;
          end
          PosCrc: begin
            emit  = 1'b1;
            pos_d = PosIdle;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    frame_d.crc_ok  = ok;
    frame_d.crc     = crc_q;
    frame_d.status  = status_q;
    frame_d.raw_hum = ok ? hum_q  : '0;
    frame_d.raw_tmp = ok ? temp_q : '0;
    if (emit)               fvalid_d = 1'b1;
    else if (frame_ready_i) fvalid_d = 1'b0;
    else                    fvalid_d = fvalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosIdle;
      crc_q    <= CrcInit;
      status_q <= '0;
      hum_q    <= '0;
      temp_q   <= '0;
      fvalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      status_q <= status_d;
      hum_q    <= hum_d;
      temp_q   <= temp_d;
      fvalid_q <= fvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) frame_q <= frame_d;
  end

  assign frame_valid_o = fvalid_q;
  assign frame_o       = frame_q;

endmodule

FILE: design/htfd_convert.sv
// Unit conversion to hundredths and the result register.
`timescale 1ns / 1ps
module htfd_convert (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frame_valid_i,
  output logic                      frame_ready_o,
  input  htfd_pkg::frame_t          frame_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      crc_ok_o,
  output logic [7:0]                computed_crc_o,
  output logic [7:0]                status_value_o,
  output logic [19:0]               raw_humidity_o,
  output logic [19:0]               raw_temperature_o,
  output logic [13:0]               humidity_centi_o,
  output logic signed [14:0]        temperature_centi_o
);
  import htfd_pkg::*;

  localparam int unsigned HumProdW  = RawW + HumW;
  localparam int unsigned TempProdW = RawW + TempW;

  logic                 ovalid_q;
  logic                 load;
  logic [HumProdW-1:0]  hum_prod;
  logic [TempProdW-1:0] temp_prod;
  logic [TempW-1:0]     temp_c;
  frame_t               res_q;
  logic [HumW-1:0]      hum_c_q;
  logic [TempW-1:0]     temp_c_q;

  assign frame_ready_o = !ovalid_q || out_ready_i;
  assign load          = frame_valid_i && frame_ready_o;

  assign hum_prod  = HumProdW'(frame_i.raw_hum) * HumProdW'(HumScale);
  assign temp_prod = TempProdW'(frame_i.raw_tmp) * TempProdW'(TempScale);
  // failed frames report zero, not the -50.00 offset
  assign temp_c    = frame_i.crc_ok ? (temp_prod[TempProdW-1:RawW] - TempOffset) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (frame_ready_o) begin
      ovalid_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q    <= frame_i;
      hum_c_q  <= hum_prod[HumProdW-1:RawW];
      temp_c_q <= temp_c;
    end
  end

  assign out_valid_o         = ovalid_q;
  assign crc_ok_o            = res_q.crc_ok;
  assign computed_crc_o      = res_q.crc;
  assign status_value_o      = res_q.status;
  assign raw_humidity_o      = res_q.raw_hum;
  assign raw_temperature_o   = res_q.raw_tmp;
  assign humidity_centi_o    = hum_c_q;
  assign temperature_centi_o = $signed(temp_c_q);

endmodule

FILE: design/humidity_temp_frame_decoder_top.sv
// Top level of the humidity / temperature frame decoder.
// The CRC byte goes into the frame register, then into the result register (two stages).
// Throughput: one byte per cycle; ready drops only while both stages are full and stalled.
// The CRC byte update is a combinational XOR network; each conversion is one constant multiply.
// Reset (async, active low) leaves no frame in progress and empties both result stages.
`timescale 1ns / 1ps
module humidity_temp_frame_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               crc_ok_o,
  output logic [7:0]         computed_crc_o,
  output logic [7:0]         status_value_o,
  output logic [19:0]        raw_humidity_o,
  output logic [19:0]        raw_temperature_o,
  output logic [13:0]        humidity_centi_o,
  output logic signed [14:0] temperature_centi_o
);
  import htfd_pkg::*;

  frame_t frame;
  logic   frame_valid;
  logic   frame_ready;

  htfd_assembler u_asm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  htfd_convert u_conv (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_valid_i       (frame_valid),
    .frame_ready_o       (frame_ready),
    .frame_i             (frame),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .crc_ok_o            (crc_ok_o),
    .computed_crc_o      (computed_crc_o),
    .status_value_o      (status_value_o),
    .raw_humidity_o      (raw_humidity_o),
    .raw_temperature_o   (raw_temperature_o),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_centi_o (temperature_centi_o)
  );

endmodule

FILE: design/htfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
`timescale 1ns / 1ps
module htfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         rx_byte_i,
  input logic               frame_start_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               crc_ok_o,
  input logic [7:0]         computed_crc_o,
  input logic [7:0]         status_value_o,
  input logic [19:0]        raw_humidity_o,
  input logic [19:0]        raw_temperature_o,
  input logic [13:0]        humidity_centi_o,
  input logic signed [14:0] temperature_centi_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(computed_crc_o)
      && $stable(status_value_o) && $stable(raw_humidity_o)
      && $stable(temperature_centi_o) && $stable(crc_ok_o))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crc_ok_o |-> raw_humidity_o == 20'd0 && raw_temperature_o == 20'd0
      && humidity_centi_o == 14'd0 && temperature_centi_o == 15'sd0)
    else $error("failed frame carries nonzero values");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_ok_o |-> humidity_centi_o <= 14'd9999)
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_ok_o |-> temperature_centi_o >= -15'sd5000)
    else $error("temperature below offset");

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (.*);

FILE: tb/sv/htfd_frame_checker.sv
// Frame decoder checker: predicts each decoded reading and compares the result beats.
`timescale 1ns / 1ps
module htfd_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               crc_ok_i,
  input  logic [7:0]         computed_crc_i,
  input  logic [7:0]         status_value_i,
  input  logic [19:0]        raw_humidity_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic [13:0]        humidity_centi_i,
  input  logic signed [14:0] temperature_centi_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  import htfd_pkg::*;

  typedef struct {
    logic               crc_ok;
    logic [7:0]         crc;
    logic [7:0]         status;
    logic [19:0]        raw_hum;
    logic [19:0]        raw_tmp;
    logic [13:0]        hum_centi;
    logic signed [14:0] temp_centi;
  } reading_t;

  reading_t expected_readings[$];
  reading_t want;

  // decoder state as seen from the byte stream
  logic [PosW-1:0] next_pos;
  logic [7:0]      crc_acc;
  logic [7:0]      status_q;
  logic [19:0]     hum_acc;
  logic [19:0]     temp_acc;

  int unsigned fails;
  int unsigned checked;

  function automatic logic [7:0] crc31_step(logic [7:0] acc, logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    repeat (8) c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    return c;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic start);
    reading_t r;
    longint unsigned hum_prod;
    longint unsigned temp_prod;
    if (start) begin
      status_q = b;
      crc_acc  = crc31_step(CrcInit, b);
      hum_acc  = '0;
      temp_acc = '0;
      next_pos = PosFirstHum;
    end else begin
      case (next_pos)
        PosFirstHum, PosSecHum: begin
          hum_acc  = {hum_acc[11:0], b};
          crc_acc  = crc31_step(crc_acc, b);
          next_pos = next_pos + 1'b1;
        end
        PosSplit: begin
          // high nibble closes humidity, low nibble opens temperature
          hum_acc  = {hum_acc[15:0], b[7:4]};
          temp_acc = {16'd0, b[3:0]};
          crc_acc  = crc31_step(crc_acc, b);
          next_pos = next_pos + 1'b1;
        end
        PosFirstTmp, PosSecTmp: begin
          temp_acc = {temp_acc[11:0], b};
          crc_acc  = crc31_step(crc_acc, b);
          next_pos = next_pos + 1'b1;
        end
        PosCrc: begin
          next_pos = PosIdle;
          r.crc_ok = (b == crc_acc);
          r.crc    = crc_acc;
          r.status = status_q;
          if (r.crc_ok) begin
            hum_prod     = (longint'(hum_acc) * 64'd10000) >> 20;
            temp_prod    = (longint'(temp_acc) * 64'd20000) >> 20;
            r.raw_hum    = hum_acc;
            r.raw_tmp    = temp_acc;
            r.hum_centi  = hum_prod[13:0];
            r.temp_centi = $signed(temp_prod[14:0]) - 15'sd5000;
          end else begin
            r.raw_hum    = '0;
            r.raw_tmp    = '0;
            r.hum_centi  = '0;
            r.temp_centi = '0;
          end
          expected_readings.push_back(r);
        end
        default: ;  // no frame open: byte dropped
      endcase
    end
  endtask

  task automatic field_check(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos = PosIdle;
      crc_acc  = CrcInit;
      status_q = '0;
      hum_acc  = '0;
      temp_acc = '0;
      fails    = 0;
      checked  = 0;
      expected_readings.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $error("result beat with no frame pending");
          fails++;
        end else begin
          want = expected_readings.pop_front();
          field_check("crc_ok", want.crc_ok, crc_ok_i);
          field_check("computed_crc", want.crc, computed_crc_i);
          field_check("status_value", want.status, status_value_i);
          field_check("raw_humidity", want.raw_hum, raw_humidity_i);
          field_check("raw_temperature", want.raw_tmp, raw_temperature_i);
          field_check("humidity_centi", want.hum_centi, humidity_centi_i);
          field_check("temperature_centi", want.temp_centi, temperature_centi_i);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) take_byte(rx_byte_i, frame_start_i);
      fail_count_o <= fails;
      pending_o    <= expected_readings.size();
      checked_o    <= checked;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the frame decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import htfd_pkg::*;

  typedef logic [6:0][7:0] frame_bytes_t;  // [0] status .. [6] crc

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               frame_start;
  logic               out_valid;
  logic               out_ready;
  logic               crc_ok;
  logic [7:0]         computed_crc;
  logic [7:0]         status_value;
  logic [19:0]        raw_humidity;
  logic [19:0]        raw_temperature;
  logic [13:0]        humidity_centi;
  logic signed [14:0] temperature_centi;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  bit          burst_mode;
  int unsigned frame_beats;
  int unsigned frames_good;
  int unsigned frames_bad;
  int unsigned frames_cut;
  int unsigned noise_beats;

  humidity_temp_frame_decoder_top uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .crc_ok_o           (crc_ok),
    .computed_crc_o     (computed_crc),
    .status_value_o     (status_value),
    .raw_humidity_o     (raw_humidity),
    .raw_temperature_o  (raw_temperature),
    .humidity_centi_o   (humidity_centi),
    .temperature_centi_o(temperature_centi)
  );

  htfd_frame_checker frame_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .crc_ok_i           (crc_ok),
    .computed_crc_i     (computed_crc),
    .status_value_i     (status_value),
    .raw_humidity_i     (raw_humidity),
    .raw_temperature_i  (raw_temperature),
    .humidity_centi_i   (humidity_centi),
    .temperature_centi_i(temperature_centi),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** humidity_temp_frame_decoder_top: FAILED **");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_data_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // fill in the CRC byte; a bad one is always off by a nonzero pattern
  function automatic frame_bytes_t sealed(frame_bytes_t fb, bit good);
    logic [7:0] c;
    c = CrcInit;
    for (int i = 0; i < 6; i++) c = crc8_byte(c, fb[i]);
    fb[6] = good ? c : c ^ 8'($urandom_range(1, 255));
    return fb;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic s);
    int unsigned idle;
    idle = burst_mode ? 0 : pick_gap();
    if (idle != 0) begin
      @(negedge clk);
      in_valid    <= 1'b0;
      rx_byte     <= 8'($urandom);
      frame_start <= 1'($urandom);
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input frame_bytes_t fb, input int unsigned len);
    for (int i = 0; i < len; i++) send_beat(fb[i], i == 0);
    frame_beats += len;
    if (len < 7) frames_cut++;
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_beat(8'($urandom), 1'b0);
    noise_beats += n;
  endtask

  // stop sending, then hold off until every reading is out
  task automatic drain_readings();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_frame();
    frame_bytes_t fb;
    bit good;
    good = $urandom_range(0, 3) != 0;
    for (int i = 0; i < 6; i++) fb[i] = (i == 0) ? 8'($urandom) : pick_data_byte();
    fb = sealed(fb, good);
    send_frame(fb, 7);
    if (good) frames_good++;
    else frames_bad++;
  endtask

  // read side: stall stretches of random length, sometimes long runs without stall
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      int unsigned stall;
      int unsigned run;
      stall = pick_gap();
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    frame_bytes_t fb;
    int unsigned  r;
    int unsigned  next_drain;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    frame_start = 1'b0;
    burst_mode  = 1'b0;
    frame_beats = 0;
    frames_good = 0;
    frames_bad  = 0;
    frames_cut  = 0;
    noise_beats = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bytes with no frame open are dropped
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    noise_beats += 2;

    // all ones: top of both scales; then a trailing byte past the CRC
    fb = sealed({7{8'hFF}}, 1'b1);
    send_frame(fb, 7);
    frames_good++;
    send_noise(1);

    // all zeros: bottom of temperature scale
    burst_mode = 1'b1;
    fb = sealed({7{8'h00}}, 1'b1);
    send_frame(fb, 7);
    frames_good++;

    // restart in mid-frame, then a frame with a wrong CRC byte
    fb = {8'h00, 8'h96, 8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'h80};
    send_frame(fb, 3);
    fb = sealed({8'h00, 8'h69, 8'hC3, 8'h3C, 8'hA5, 8'h5A, 8'h7F}, 1'b0);
    send_frame(fb, 7);
    frames_bad++;
    burst_mode = 1'b0;
    drain_readings();

    next_drain = frame_beats + 400;
    while (frame_beats + noise_beats < 1600) begin
      if ($urandom_range(0, 15) == 0) burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        random_frame();
      end else if (r < 88) begin
        for (int i = 0; i < 7; i++) fb[i] = pick_data_byte();
        send_frame(fb, $urandom_range(1, 6));
      end else if (r < 95) begin
        send_noise($urandom_range(1, 4));
      end else begin
        random_frame();
        send_noise($urandom_range(1, 3));
      end
      if (frame_beats >= next_drain) begin
        drain_readings();
        next_drain += 400;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run: %0d frame beats, %0d good-CRC and %0d bad-CRC frames, %0d cut short,",
             frame_beats, frames_good, frames_bad, frames_cut);
    $display("     %0d stray beats sent, %0d readings checked.", noise_beats, checked);
    if (fail_count == 0) begin
      $display("** humidity_temp_frame_decoder_top: PASSED **");
    end else begin
      $display("** humidity_temp_frame_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
